>>> rtl/core/feg_pkg.sv
// Package for the filter envelope generator core.
// Holds command, phase and direction codes, register indexes and the step table.
// Depends on nothing; every other file of the core refers to it by scoped names.
`timescale 1ns / 1ps

package feg_pkg;

  // Fixed field widths
  localparam int CMD_W       = 2;
  localparam int CNT_W       = 14;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_LEVEL_W = 13;
  localparam int RATES_W     = 20;
  localparam int KS_W        = 10;
  localparam int PH_RATE_W   = 5;
  localparam int EFF_RATE_W  = 7;
  localparam int STEP_W      = 4;

  // Input commands; the fourth code is ignored
  typedef enum logic [CMD_W-1:0] {
    CMD_CLOCK   = 2'd0,
    CMD_KEY_ON  = 2'd1,
    CMD_KEY_OFF = 2'd2
  } cmd_t;

  // Envelope phases
  typedef enum logic [1:0] {
    PH_ATTACK    = 2'd0,
    PH_DECAY_ONE = 2'd1,
    PH_DECAY_TWO = 2'd2,
    PH_RELEASE   = 2'd3
  } phase_t;

  // Direction of movement towards the phase target
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_START     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ATTACK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_DECAY_ONE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_DECAY_TWO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_RELEASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATES           = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SCALING     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_OFFSET  = 3'd7;

  // Register reset values that are not zero
  localparam logic [KS_W-1:0] KS_RESET = 10'd15;

  // Rate constants
  localparam logic [3:0]            KS_OFF     = 4'd15;
  localparam logic [EFF_RATE_W-1:0] RATE_MAX   = 7'd63;
  localparam logic [EFF_RATE_W-1:0] RATE_FAST  = 7'd48;
  localparam logic [EFF_RATE_W-1:0] RATE_TOP   = 7'd60;
  localparam logic [3:0]            SHIFT_BASE = 4'd11;
  localparam logic [4:0]            ROW_FAST   = 5'd4;
  localparam logic [4:0]            ROW_TOP    = 5'd16;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [CFG_LEVEL_W-1:0] level_start;
    logic [CFG_LEVEL_W-1:0] level_attack;
    logic [CFG_LEVEL_W-1:0] level_decay_one;
    logic [CFG_LEVEL_W-1:0] level_decay_two;
    logic [CFG_LEVEL_W-1:0] level_release;
    logic [RATES_W-1:0]     rates;
    logic [KS_W-1:0]        key_scaling;
    logic [CNT_W-1:0]       counter_offset;
  } cfg_t;

  // Increment table: one row of eight nibbles per entry, slot 0 in the low nibble
  localparam logic [31:0] STEP_ROWS [17] = '{
    32'h10101010, 32'h10111010, 32'h11101110, 32'h11111110,
    32'h11111111, 32'h21112111, 32'h21212121, 32'h22212221,
    32'h22222222, 32'h42224222, 32'h42424242, 32'h44424442,
    32'h44444444, 32'h84448444, 32'h84848484, 32'h88848884,
    32'h88888888
  };

  // Look up one increment from the table
  function automatic logic [STEP_W-1:0] step_lookup(input logic [4:0] row,
                                                    input logic [2:0] slot);
    logic [31:0] bits;
    bits = (row <= ROW_TOP) ? STEP_ROWS[row] : 32'h0;
    return bits[slot*STEP_W +: STEP_W];
  endfunction

endpackage

>>> rtl/core/filter_envelope_generator_core.sv
// Top level of the filter envelope generator core.
// Input register, envelope state, result register and configuration file.
// Depends on feg_pkg, feg_cfg and feg_next (which uses feg_rate).
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid/in_ready) carries one envelope clock, key-on
// or key-off per transaction, with the global counter value in in_counter.
// Every input transaction yields exactly one result transaction on the output
// channel (out_valid/out_ready): the level and phase after that input.
// Registers are written through cfg_we/cfg_index/cfg_data while the core is
// idle; a write takes effect at the clock edge that carries it.
// An accepted item waits in the input register until the result register is
// free or being emptied; then the next-state logic updates the envelope state
// and the result register together.
// Throughput is one transaction per cycle while the receiver takes results;
// the envelope state is updated as each item leaves the input register.
// Reset (rst_n low, synchronous) clears both valid flags, returns the
// registers to their reset values and puts the envelope in release, level
// zero, finished. While the receiver stalls the result register holds; the
// input register takes at most one more transaction, and once it is full
// in_ready stays low until the result is taken.

module filter_envelope_generator_core #(
  parameter int LEVEL_BITS = 13
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [feg_pkg::CMD_W-1:0]        in_cmd,
  input  logic [feg_pkg::CNT_W-1:0]        in_counter,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [LEVEL_BITS-1:0]            out_level,
  output logic [1:0]                       out_phase,
  input  logic                             cfg_we,
  input  logic [feg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [feg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  feg_pkg::cfg_t               cfg;
  logic                        in_valid_r;
  logic [feg_pkg::CMD_W-1:0]   in_cmd_r;
  logic [feg_pkg::CNT_W-1:0]   in_counter_r;
  logic                        out_valid_r;
  logic [LEVEL_BITS-1:0]       out_level_r;
  feg_pkg::phase_t             out_phase_r;
  logic [LEVEL_BITS-1:0]       level_r;
  logic [LEVEL_BITS-1:0]       level_nxt;
  feg_pkg::phase_t             phase_r;
  feg_pkg::phase_t             phase_nxt;
  feg_pkg::dir_t               dir_r;
  feg_pkg::dir_t               dir_nxt;
  logic                        done_r;
  logic                        done_nxt;
  logic                        advance;

  feg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The result register is free, or is being emptied this cycle
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_cmd_r     <= in_cmd;
      in_counter_r <= in_counter;
    end
  end

  feg_next #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_next (
    .cfg       (cfg),
    .cmd       (in_cmd_r),
    .counter   (in_counter_r),
    .level     (level_r),
    .phase     (phase_r),
    .dir       (dir_r),
    .done      (done_r),
    .level_nxt (level_nxt),
    .phase_nxt (phase_nxt),
    .dir_nxt   (dir_nxt),
    .done_nxt  (done_nxt)
  );

  // Envelope state, updated when an item leaves the input register, and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      phase_r     <= feg_pkg::PH_RELEASE;
      dir_r       <= feg_pkg::DIR_NONE;
      done_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        level_r <= level_nxt;
        phase_r <= phase_nxt;
        dir_r   <= dir_nxt;
        done_r  <= done_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_level_r <= level_nxt;
      out_phase_r <= phase_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_phase = out_phase_r;

endmodule

>>> rtl/core/feg_cfg.sv
// Configuration register file of the filter envelope generator.
// Stores the eight registers written through the plain write port.
// Depends on feg_pkg.
`timescale 1ns / 1ps

module feg_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [feg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [feg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output feg_pkg::cfg_t                    cfg
);

  feg_pkg::cfg_t cfg_r;

  // Register writes, each value masked to its register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_start     <= '0;
      cfg_r.level_attack    <= '0;
      cfg_r.level_decay_one <= '0;
      cfg_r.level_decay_two <= '0;
      cfg_r.level_release   <= '0;
      cfg_r.rates           <= '0;
      cfg_r.key_scaling     <= feg_pkg::KS_RESET;
      cfg_r.counter_offset  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        feg_pkg::REG_LEVEL_START:     cfg_r.level_start     <= cfg_data[feg_pkg::CFG_LEVEL_W-1:0];
        feg_pkg::REG_LEVEL_ATTACK:    cfg_r.level_attack    <= cfg_data[feg_pkg::CFG_LEVEL_W-1:0];
        feg_pkg::REG_LEVEL_DECAY_ONE: cfg_r.level_decay_one <= cfg_data[feg_pkg::CFG_LEVEL_W-1:0];
        feg_pkg::REG_LEVEL_DECAY_TWO: cfg_r.level_decay_two <= cfg_data[feg_pkg::CFG_LEVEL_W-1:0];
        feg_pkg::REG_LEVEL_RELEASE:   cfg_r.level_release   <= cfg_data[feg_pkg::CFG_LEVEL_W-1:0];
        feg_pkg::REG_RATES:           cfg_r.rates           <= cfg_data[feg_pkg::RATES_W-1:0];
        feg_pkg::REG_KEY_SCALING:     cfg_r.key_scaling     <= cfg_data[feg_pkg::KS_W-1:0];
        feg_pkg::REG_COUNTER_OFFSET:  cfg_r.counter_offset  <= cfg_data[feg_pkg::CNT_W-1:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/feg_rate.sv
// Effective rate and step size of the filter envelope generator.
// Combines phase rate, key-rate scaling and the counter into one increment.
// Depends on feg_pkg.
`timescale 1ns / 1ps

module feg_rate (
  input  feg_pkg::cfg_t                    cfg,
  input  feg_pkg::phase_t                  phase,
  input  logic [feg_pkg::CNT_W-1:0]        counter,
  output logic [feg_pkg::STEP_W-1:0]       step
);

  logic [feg_pkg::PH_RATE_W-1:0]  ph_rate;
  logic signed [5:0]              key_sum;
  logic [3:0]                     key_clip;
  logic [4:0]                     scale;
  logic [feg_pkg::EFF_RATE_W-1:0] rate_raw;
  logic [feg_pkg::EFF_RATE_W-1:0] rate;
  logic [3:0]                     shift;
  logic [feg_pkg::CNT_W-1:0]      cnt_off;
  logic [feg_pkg::CNT_W-1:0]      cnt_mask;
  logic [feg_pkg::CNT_W-1:0]      cnt_shift;
  logic [4:0]                     fast_row;

  // Select the 5-bit rate of the active phase
  always_comb begin
    case (phase)
      feg_pkg::PH_ATTACK:    ph_rate = cfg.rates[4:0];
      feg_pkg::PH_DECAY_ONE: ph_rate = cfg.rates[9:5];
      feg_pkg::PH_DECAY_TWO: ph_rate = cfg.rates[14:10];
      feg_pkg::PH_RELEASE:   ph_rate = cfg.rates[19:15];
      default:               ph_rate = '0;
    endcase
  end

  // Key-rate scaling: key scale plus signed octave, clipped to 15, with the fns bit below
  always_comb begin
    key_sum  = $signed({2'b00, cfg.key_scaling[3:0]})
             + $signed({{2{cfg.key_scaling[7]}}, cfg.key_scaling[7:4]});
    key_clip = (key_sum > 6'sd15) ? 4'd15 : key_sum[3:0];
    if (cfg.key_scaling[9] && (cfg.key_scaling[3:0] != feg_pkg::KS_OFF) && !key_sum[5]) begin
      scale = {key_clip, cfg.key_scaling[8]};
    end else begin
      scale = '0;
    end
    rate_raw = {1'b0, ph_rate, 1'b0} + {2'b00, scale};
    rate     = (rate_raw > feg_pkg::RATE_MAX) ? feg_pkg::RATE_MAX : rate_raw;
  end

  // Slow rates step only where the offset counter's low bits are clear
  always_comb begin
    shift     = feg_pkg::SHIFT_BASE - rate[5:2];
    cnt_off   = counter + cfg.counter_offset;
    cnt_mask  = (feg_pkg::CNT_W'(1) << shift) - feg_pkg::CNT_W'(1);
    cnt_shift = cnt_off >> shift;
    fast_row  = (rate >= feg_pkg::RATE_TOP) ? feg_pkg::ROW_TOP
              : feg_pkg::ROW_FAST + 5'(rate - feg_pkg::RATE_FAST);
    if (ph_rate == '0) begin
      step = '0;
    end else if (rate < feg_pkg::RATE_FAST) begin
      step = ((cnt_off & cnt_mask) == '0)
           ? feg_pkg::step_lookup({3'b000, rate[1:0]}, cnt_shift[2:0]) : '0;
    end else begin
      step = feg_pkg::step_lookup(fast_row, counter[2:0]);
    end
  end

endmodule

>>> rtl/core/feg_next.sv
// Next-state logic of the filter envelope generator.
// Handles key-on, key-off, phase advance and the clamped step towards the target.
// Depends on feg_pkg and feg_rate.
`timescale 1ns / 1ps

module feg_next #(
  parameter int LEVEL_BITS = 13
) (
  input  feg_pkg::cfg_t                cfg,
  input  logic [feg_pkg::CMD_W-1:0]    cmd,
  input  logic [feg_pkg::CNT_W-1:0]    counter,
  input  logic [LEVEL_BITS-1:0]        level,
  input  feg_pkg::phase_t              phase,
  input  feg_pkg::dir_t                dir,
  input  logic                         done,
  output logic [LEVEL_BITS-1:0]        level_nxt,
  output feg_pkg::phase_t              phase_nxt,
  output feg_pkg::dir_t                dir_nxt,
  output logic                         done_nxt
);

  localparam int ExtW = (LEVEL_BITS > feg_pkg::CFG_LEVEL_W) ? LEVEL_BITS : feg_pkg::CFG_LEVEL_W;

  feg_pkg::phase_t              ph_mid;
  feg_pkg::phase_t              ph_adv;
  feg_pkg::dir_t                dir_mid;
  logic                         done_mid;
  logic [LEVEL_BITS-1:0]        t_start;
  logic [LEVEL_BITS-1:0]        t_attack;
  logic [LEVEL_BITS-1:0]        t_release;
  logic [LEVEL_BITS-1:0]        t_mid;
  logic [LEVEL_BITS-1:0]        t_adv;
  logic [feg_pkg::STEP_W-1:0]   step;
  logic [LEVEL_BITS:0]          up_sum;
  logic [LEVEL_BITS:0]          down_diff;

  // Fit a stored level register to the level width
  function automatic logic [LEVEL_BITS-1:0] fit_level(input logic [feg_pkg::CFG_LEVEL_W-1:0] v);
    logic [ExtW-1:0] ext;
    ext = ExtW'(v);
    return ext[LEVEL_BITS-1:0];
  endfunction

  // Target level of a phase
  function automatic logic [LEVEL_BITS-1:0] target_of(input feg_pkg::phase_t ph);
    logic [feg_pkg::CFG_LEVEL_W-1:0] v;
    case (ph)
      feg_pkg::PH_ATTACK:    v = cfg.level_attack;
      feg_pkg::PH_DECAY_ONE: v = cfg.level_decay_one;
      feg_pkg::PH_DECAY_TWO: v = cfg.level_decay_two;
      feg_pkg::PH_RELEASE:   v = cfg.level_release;
      default:               v = '0;
    endcase
    return fit_level(v);
  endfunction

  // Direction from a level towards a target
  function automatic feg_pkg::dir_t dir_toward(input logic [LEVEL_BITS-1:0] lvl,
                                               input logic [LEVEL_BITS-1:0] tgt);
    feg_pkg::dir_t d;
    if (lvl < tgt) begin
      d = feg_pkg::DIR_UP;
    end else if (lvl > tgt) begin
      d = feg_pkg::DIR_DOWN;
    end else begin
      d = feg_pkg::DIR_NONE;
    end
    return d;
  endfunction

  // A key-off clock enters release before the clock itself is handled
  always_comb begin
    t_start   = fit_level(cfg.level_start);
    t_attack  = target_of(feg_pkg::PH_ATTACK);
    t_release = target_of(feg_pkg::PH_RELEASE);
    if (cmd == feg_pkg::CMD_KEY_OFF) begin
      ph_mid   = feg_pkg::PH_RELEASE;
      dir_mid  = dir_toward(level, t_release);
      done_mid = (level == t_release);
    end else begin
      ph_mid   = phase;
      dir_mid  = dir;
      done_mid = done;
    end
    t_mid  = target_of(ph_mid);
    ph_adv = feg_pkg::phase_t'(ph_mid + 2'd1);
    t_adv  = target_of(ph_adv);
  end

  feg_rate u_rate (
    .cfg     (cfg),
    .phase   (ph_mid),
    .counter (counter),
    .step    (step)
  );

  // Key-on restart, phase advance, or one step towards the target, clamped so it does not pass it
  always_comb begin
    up_sum    = {1'b0, level} + (LEVEL_BITS + 1)'(step);
    down_diff = {1'b0, level} - (LEVEL_BITS + 1)'(step);
    level_nxt = level;
    phase_nxt = phase;
    dir_nxt   = dir;
    done_nxt  = done;
    case (cmd)
      feg_pkg::CMD_KEY_ON: begin
        level_nxt = t_start;
        phase_nxt = feg_pkg::PH_ATTACK;
        dir_nxt   = dir_toward(t_start, t_attack);
        done_nxt  = (t_start == t_attack);
      end
      feg_pkg::CMD_CLOCK, feg_pkg::CMD_KEY_OFF: begin
        phase_nxt = ph_mid;
        dir_nxt   = dir_mid;
        done_nxt  = done_mid;
        if (done_mid && (ph_mid < feg_pkg::PH_DECAY_TWO)) begin
          phase_nxt = ph_adv;
          dir_nxt   = dir_toward(level, t_adv);
          done_nxt  = (level == t_adv);
        end else if (!done_mid && (step != '0)) begin
          if (dir_mid == feg_pkg::DIR_UP) begin
            if (up_sum >= {1'b0, t_mid}) begin
              level_nxt = t_mid;
              done_nxt  = 1'b1;
            end else begin
              level_nxt = up_sum[LEVEL_BITS-1:0];
            end
          end else begin
            if (down_diff[LEVEL_BITS] || (down_diff[LEVEL_BITS-1:0] <= t_mid)) begin
              level_nxt = t_mid;
              done_nxt  = 1'b1;
            end else begin
              level_nxt = down_diff[LEVEL_BITS-1:0];
            end
          end
        end
      end
      default: begin
        level_nxt = level;
      end
    endcase
  end

endmodule

>>> rtl/core/feg_checker.sv
// Port-level checker for the filter envelope generator core.
// Watches the handshakes of the top level and is attached by the bind below.
// Depends on filter_envelope_generator_core and feg_pkg.
`timescale 1ns / 1ps

module feg_checker #(
  parameter int LEVEL_BITS = 13
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [feg_pkg::CMD_W-1:0]      in_cmd,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [LEVEL_BITS-1:0]          out_level,
  input logic [1:0]                     out_phase
);

  // Reset empties the result channel
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_phase))
    else $error("stalled result changed");

  // Whenever the result register can move, the input side accepts
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input not ready while result path is free");

  // A key-on accepted onto an empty core reports attack once it has passed the input and result registers
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == feg_pkg::CMD_KEY_ON) && !out_valid && in_ready
      ##1 (!out_valid && in_ready) |=> out_valid && (out_phase == feg_pkg::PH_ATTACK))
    else $error("key-on did not report the attack phase");

endmodule

bind filter_envelope_generator_core feg_checker #(
  .LEVEL_BITS (LEVEL_BITS)
) u_feg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_cmd    (in_cmd),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_level (out_level),
  .out_phase (out_phase)
);

>>> dv/tb_filter_envelope_generator_core.sv
// Self-checking testbench for the filter envelope generator core.
// Directed rows and then random envelope traffic, checked against set values or an envelope predictor.
// Depends on feg_pkg and filter_envelope_generator_core.
`timescale 1ns / 1ps

module tb_filter_envelope_generator_core;

  localparam int LEVEL_BITS = 13;
  localparam int LEVEL_MAX = (1 << LEVEL_BITS) - 1;
  localparam logic [feg_pkg::CMD_W-1:0] CMD_IGNORED = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int NUM_SEGMENTS = 8;
  localparam int SEGMENT_ITEMS = 125;
  localparam int REPORT_LIMIT = 10;
  localparam int MAX_GAP = 16;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    feg_pkg::phase_t       phase;
  } envelope_t;

  typedef enum {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    logic [feg_pkg::CFG_IDX_W-1:0]   idx;
    logic [feg_pkg::CFG_DATA_W-1:0]  data;
    logic [feg_pkg::CMD_W-1:0]       cmd;
    logic [feg_pkg::CNT_W-1:0]       cnt;
    bit                              typed;
    envelope_t                       want;
  } script_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [feg_pkg::CMD_W-1:0]       in_cmd = '0;
  logic [feg_pkg::CNT_W-1:0]       in_counter = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [LEVEL_BITS-1:0]           out_level;
  logic [1:0]                      out_phase;
  logic                            cfg_we = 1'b0;
  logic [feg_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [feg_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Predicted envelope state and the register values it works from
  int                              tracked_level = 0;
  feg_pkg::phase_t                 tracked_phase = feg_pkg::PH_RELEASE;
  feg_pkg::dir_t                   tracked_dir = feg_pkg::DIR_NONE;
  bit                              tracked_done = 1'b1;
  logic [feg_pkg::CFG_DATA_W-1:0]  reg_copy [8];

  envelope_t              envelope_due [$];
  script_row_t            script [$];
  int                     gap_pct = 0;
  int                     stall_pct = 0;
  int                     error_count = 0;

  filter_envelope_generator_core #(
    .LEVEL_BITS(LEVEL_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_counter (in_counter),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_level  (out_level),
    .out_phase  (out_phase),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Target level of a phase, taken from the level registers in phase order.
  function automatic int level_target(feg_pkg::phase_t ph);
    return int'(reg_copy[int'(feg_pkg::REG_LEVEL_ATTACK) + int'(ph)]) & LEVEL_MAX;
  endfunction

  task automatic enter_phase(feg_pkg::phase_t ph);
    int tgt;
    tgt = level_target(ph);
    tracked_phase = ph;
    if (tracked_level < tgt) begin
      tracked_dir = feg_pkg::DIR_UP;
    end else if (tracked_level > tgt) begin
      tracked_dir = feg_pkg::DIR_DOWN;
    end else begin
      tracked_dir = feg_pkg::DIR_NONE;
    end
    tracked_done = (tracked_dir == feg_pkg::DIR_NONE);
  endtask

  // Twice the phase rate plus the key-rate term, saturated.
  function automatic int effective_rate(feg_pkg::phase_t ph);
    int base;
    int oct;
    int key;
    int boost;
    int sum;
    logic [feg_pkg::KS_W-1:0] ks;
    base = int'((reg_copy[feg_pkg::REG_RATES] >> (feg_pkg::PH_RATE_W * int'(ph))) & 20'h1F);
    ks = reg_copy[feg_pkg::REG_KEY_SCALING][feg_pkg::KS_W-1:0];
    boost = 0;
    if (base == 0) return 0;
    if (ks[9] && ks[3:0] != feg_pkg::KS_OFF) begin
      oct = int'(ks[7:4]);
      if (ks[7]) oct -= 16;
      key = int'(ks[3:0]) + oct;
      if (key >= 0) boost = 2 * ((key > 15) ? 15 : key) + int'(ks[8]);
    end
    sum = 2 * base + boost;
    return (sum > int'(feg_pkg::RATE_MAX)) ? int'(feg_pkg::RATE_MAX) : sum;
  endfunction

  // Increment table, one row per line, slot 0 in the leftmost digit.
  function automatic int increment_of(int row, int slot);
    logic [31:0] digits;
    case (row)
      0:       digits = 32'h01010101;
      1:       digits = 32'h01011101;
      2:       digits = 32'h01110111;
      3:       digits = 32'h01111111;
      4:       digits = 32'h11111111;
      5:       digits = 32'h11121112;
      6:       digits = 32'h12121212;
      7:       digits = 32'h12221222;
      8:       digits = 32'h22222222;
      9:       digits = 32'h22242224;
      10:      digits = 32'h24242424;
      11:      digits = 32'h24442444;
      12:      digits = 32'h44444444;
      13:      digits = 32'h44484448;
      14:      digits = 32'h48484848;
      15:      digits = 32'h48884888;
      default: digits = 32'h88888888;
    endcase
    return int'((digits >> (4 * (7 - slot))) & 32'hF);
  endfunction

  // Slow rates step only on aligned counter values; fast rates step every clock.
  function automatic int step_increment(int rate, logic [feg_pkg::CNT_W-1:0] cnt);
    int shift;
    logic [feg_pkg::CNT_W-1:0] pos;
    if (rate == 0) return 0;
    if (rate < int'(feg_pkg::RATE_FAST)) begin
      shift = int'(feg_pkg::SHIFT_BASE) - (rate >> 2);
      pos = cnt + reg_copy[feg_pkg::REG_COUNTER_OFFSET][feg_pkg::CNT_W-1:0];
      if ((int'(pos) & ((1 << shift) - 1)) != 0) return 0;
      return increment_of(rate & 3, (int'(pos) >> shift) & 7);
    end
    if (rate >= int'(feg_pkg::RATE_TOP)) begin
      return increment_of(int'(feg_pkg::ROW_TOP), int'(cnt) & 7);
    end
    return increment_of(int'(feg_pkg::ROW_FAST) + rate - int'(feg_pkg::RATE_FAST),
                        int'(cnt) & 7);
  endfunction

  // Moves the predicted envelope by one input and returns the level and phase after it.
  task automatic advance_envelope(input logic [feg_pkg::CMD_W-1:0] cmd,
                                  input logic [feg_pkg::CNT_W-1:0] cnt,
                                  output envelope_t result);
    int tgt;
    int inc;
    bit held;
    held = 1'b0;
    if (cmd == feg_pkg::CMD_KEY_ON) begin
      tracked_level = int'(reg_copy[feg_pkg::REG_LEVEL_START]) & LEVEL_MAX;
      enter_phase(feg_pkg::PH_ATTACK);
    end else if (cmd != CMD_IGNORED) begin
      if (cmd == feg_pkg::CMD_KEY_OFF) enter_phase(feg_pkg::PH_RELEASE);
      // A finished attack or first decay only moves on to the next phase.
      if (tracked_done && tracked_phase < feg_pkg::PH_DECAY_TWO) begin
        enter_phase(feg_pkg::phase_t'(int'(tracked_phase) + 1));
        held = 1'b1;
      end
      if (!held && !tracked_done) begin
        tgt = level_target(tracked_phase);
        inc = step_increment(effective_rate(tracked_phase), cnt);
        if (inc != 0) begin
          if (tracked_dir == feg_pkg::DIR_UP) begin
            tracked_level += inc;
            if (tracked_level >= tgt) begin
              tracked_level = tgt;
              tracked_done = 1'b1;
            end
          end else begin
            tracked_level -= inc;
            if (tracked_level <= tgt) begin
              tracked_level = tgt;
              tracked_done = 1'b1;
            end
          end
          if (tracked_level < 0) tracked_level = 0;
          if (tracked_level > LEVEL_MAX) tracked_level = LEVEL_MAX;
        end
      end
    end
    result.level = tracked_level[LEVEL_BITS-1:0];
    result.phase = tracked_phase;
  endtask

  // Offers one transaction, waits for it to be taken and records what should come back.
  task automatic send_item(input logic [feg_pkg::CMD_W-1:0] cmd,
                           input logic [feg_pkg::CNT_W-1:0] cnt,
                           input bit typed, input envelope_t want);
    int gap;
    envelope_t due;
    gap = 0;
    while (gap < MAX_GAP && int'($urandom_range(99)) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_counter <= cnt;
    do @(posedge clk); while (!in_ready);
    advance_envelope(cmd, cnt, due);
    envelope_due.insert(envelope_due.size(), typed ? want : due);
  endtask

  // Holds the sender back until every outstanding result has been seen.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (envelope_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [feg_pkg::CFG_IDX_W-1:0] idx,
                                input logic [feg_pkg::CFG_DATA_W-1:0] data);
    logic [feg_pkg::CFG_DATA_W-1:0] mask;
    wait_for_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      feg_pkg::REG_RATES:          mask = 20'hFFFFF;
      feg_pkg::REG_KEY_SCALING:    mask = 20'h003FF;
      feg_pkg::REG_COUNTER_OFFSET: mask = 20'h03FFF;
      default:                     mask = 20'h01FFF;
    endcase
    reg_copy[idx] = data & mask;
  endtask

  task automatic add_write(input logic [feg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [feg_pkg::CFG_DATA_W-1:0] data);
    script_row_t row;
    row.kind = ROW_WRITE;
    row.idx = idx;
    row.data = data;
    row.cmd = feg_pkg::CMD_CLOCK;
    row.cnt = '0;
    row.typed = 1'b0;
    row.want = '0;
    script.insert(script.size(), row);
  endtask

  task automatic add_item(input logic [feg_pkg::CMD_W-1:0] cmd,
                          input logic [feg_pkg::CNT_W-1:0] cnt,
                          input bit typed, input int level, input feg_pkg::phase_t ph);
    script_row_t row;
    row.kind = ROW_ITEM;
    row.idx = '0;
    row.data = '0;
    row.cmd = cmd;
    row.cnt = cnt;
    row.typed = typed;
    row.want.level = level[LEVEL_BITS-1:0];
    row.want.phase = ph;
    script.insert(script.size(), row);
  endtask

  function automatic logic [feg_pkg::CFG_DATA_W-1:0] near_level(int base);
    int v;
    v = base + int'($urandom_range(400)) - 200;
    if (v < 0) v = 0;
    if (v > LEVEL_MAX) v = LEVEL_MAX;
    return v[feg_pkg::CFG_DATA_W-1:0];
  endfunction

  // Phase rates lean towards the fast end so that phases finish within a segment.
  function automatic logic [feg_pkg::PH_RATE_W-1:0] random_rate();
    case ($urandom_range(3))
      0:       return '0;
      3:       return feg_pkg::PH_RATE_W'($urandom_range(31));
      default: return feg_pkg::PH_RATE_W'($urandom_range(31, 24));
    endcase
  endfunction

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_ready <= (int'($urandom_range(99)) >= stall_pct);
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    envelope_t due;
    if (rst_n && out_valid && out_ready) begin
      if (envelope_due.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected result: level %0d phase %0d", out_level, out_phase);
      end else begin
        due = envelope_due.pop_front();
        if (out_level !== due.level || out_phase !== due.phase) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("mismatch: expected level %0d phase %0d, got level %0d phase %0d",
                     due.level, due.phase, out_level, out_phase);
        end
      end
    end
  end

  initial begin
    int base;
    int pick;
    logic [feg_pkg::CMD_W-1:0] cmd;
    logic [feg_pkg::CNT_W-1:0] cnt;
    logic [feg_pkg::CFG_DATA_W-1:0] setting [8];

    foreach (reg_copy[i]) reg_copy[i] = '0;
    reg_copy[feg_pkg::REG_KEY_SCALING] = feg_pkg::CFG_DATA_W'(feg_pkg::KS_RESET);

    // Straight after reset everything sits at zero in a finished release.
    add_item(feg_pkg::CMD_CLOCK,   14'h0000, 1, 0, feg_pkg::PH_RELEASE);
    add_item(CMD_IGNORED,          14'h3FFF, 1, 0, feg_pkg::PH_RELEASE);
    add_item(feg_pkg::CMD_KEY_ON,  14'h0000, 1, 0, feg_pkg::PH_ATTACK);
    add_item(feg_pkg::CMD_CLOCK,   14'h3FFF, 1, 0, feg_pkg::PH_DECAY_ONE);
    add_item(feg_pkg::CMD_CLOCK,   14'h0000, 1, 0, feg_pkg::PH_DECAY_TWO);
    add_item(feg_pkg::CMD_CLOCK,   14'h1555, 1, 0, feg_pkg::PH_DECAY_TWO);
    add_item(feg_pkg::CMD_KEY_OFF, 14'h0000, 1, 0, feg_pkg::PH_RELEASE);
    // Start, attack and decay targets at the top of the range, release target zero; attack,
    // decay1 and release at the fastest rate, decay2 at the slowest one that still moves.
    add_write(feg_pkg::REG_LEVEL_START,     20'd8180);
    add_write(feg_pkg::REG_LEVEL_ATTACK,    20'd8191);
    add_write(feg_pkg::REG_LEVEL_DECAY_ONE, 20'd8185);
    add_write(feg_pkg::REG_LEVEL_DECAY_TWO, 20'd8180);
    add_write(feg_pkg::REG_LEVEL_RELEASE,   20'd0);
    add_write(feg_pkg::REG_RATES,           20'hF87FF);
    add_item(feg_pkg::CMD_KEY_ON,  14'h0000, 1, 8180, feg_pkg::PH_ATTACK);
    add_item(feg_pkg::CMD_CLOCK,   14'h0000, 1, 8188, feg_pkg::PH_ATTACK);
    add_item(feg_pkg::CMD_CLOCK,   14'h0005, 1, 8191, feg_pkg::PH_ATTACK);
    add_item(feg_pkg::CMD_CLOCK,   14'h0000, 1, 8191, feg_pkg::PH_DECAY_ONE);
    add_item(feg_pkg::CMD_CLOCK,   14'h0007, 1, 8185, feg_pkg::PH_DECAY_ONE);
    add_item(feg_pkg::CMD_CLOCK,   14'h0000, 1, 8185, feg_pkg::PH_DECAY_TWO);
    add_item(feg_pkg::CMD_CLOCK,   14'h0001, 0, 0, feg_pkg::PH_ATTACK);
    add_item(feg_pkg::CMD_CLOCK,   14'h0800, 0, 0, feg_pkg::PH_ATTACK);
    add_item(feg_pkg::CMD_KEY_OFF, 14'h3FFF, 0, 0, feg_pkg::PH_ATTACK);
    // Key scaling on with a negative octave, full counter offset, attack rate zero.
    add_write(feg_pkg::REG_KEY_SCALING,    20'h003F0);
    add_write(feg_pkg::REG_COUNTER_OFFSET, 20'h03FFF);
    add_write(feg_pkg::REG_RATES,          20'hF87E0);
    add_write(feg_pkg::REG_LEVEL_START,    20'd0);
    add_item(feg_pkg::CMD_KEY_ON,  14'h0000, 1, 0, feg_pkg::PH_ATTACK);
    add_item(feg_pkg::CMD_CLOCK,   14'h0000, 1, 0, feg_pkg::PH_ATTACK);
    add_item(feg_pkg::CMD_CLOCK,   14'h3FFF, 1, 0, feg_pkg::PH_ATTACK);
    add_item(feg_pkg::CMD_KEY_OFF, 14'h2A55, 0, 0, feg_pkg::PH_ATTACK);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        write_register(script[i].idx, script[i].data);
      end else begin
        send_item(script[i].cmd, script[i].cnt, script[i].typed, script[i].want);
      end
    end

    // Random segments, each with its own register setting and idling pattern.
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      case (seg)
        0: begin
          foreach (setting[i]) setting[i] = 20'hFFFFF;
        end
        1: begin
          foreach (setting[i]) setting[i] = 20'h00000;
        end
        2: begin
          setting[feg_pkg::REG_LEVEL_START]     = 20'd0;
          setting[feg_pkg::REG_LEVEL_ATTACK]    = 20'd8191;
          setting[feg_pkg::REG_LEVEL_DECAY_ONE] = 20'd0;
          setting[feg_pkg::REG_LEVEL_DECAY_TWO] = 20'd8191;
          setting[feg_pkg::REG_LEVEL_RELEASE]   = 20'd0;
          setting[feg_pkg::REG_RATES]           = 20'hFFFFF;
          setting[feg_pkg::REG_KEY_SCALING]     = 20'h00307;
          setting[feg_pkg::REG_COUNTER_OFFSET]  = 20'd0;
        end
        default: begin
          base = int'($urandom_range(LEVEL_MAX));
          setting[feg_pkg::REG_LEVEL_START]     = near_level(base);
          setting[feg_pkg::REG_LEVEL_ATTACK]    = near_level(base);
          setting[feg_pkg::REG_LEVEL_DECAY_ONE] = near_level(base);
          setting[feg_pkg::REG_LEVEL_DECAY_TWO] = near_level(base);
          setting[feg_pkg::REG_LEVEL_RELEASE]   = near_level(base);
          setting[feg_pkg::REG_RATES] =
            {random_rate(), random_rate(), random_rate(), random_rate()};
          setting[feg_pkg::REG_KEY_SCALING] =
            feg_pkg::CFG_DATA_W'($urandom_range(1023));
          setting[feg_pkg::REG_COUNTER_OFFSET] =
            feg_pkg::CFG_DATA_W'($urandom_range(16383));
        end
      endcase
      for (int r = 0; r < 8; r++) write_register(r[feg_pkg::CFG_IDX_W-1:0], setting[r]);

      case (seg % 4)
        0: begin
          gap_pct   <= 0;
          stall_pct <= 0;
        end
        1: begin
          gap_pct   <= 51;
          stall_pct <= 0;
        end
        2: begin
          gap_pct   <= 0;
          stall_pct <= 51;
        end
        default: begin
          gap_pct   <= 8;
          stall_pct <= 8;
        end
      endcase

      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        // Halfway through, the sender stops until the pipeline has emptied.
        if (n == SEGMENT_ITEMS / 2) wait_for_idle();
        pick = int'($urandom_range(99));
        if (n == 0 || pick < 6) begin
          cmd = feg_pkg::CMD_KEY_ON;
        end else if (pick < 12) begin
          cmd = feg_pkg::CMD_KEY_OFF;
        end else if (pick < 15) begin
          cmd = CMD_IGNORED;
        end else begin
          cmd = feg_pkg::CMD_CLOCK;
        end
        // Half the counters are aligned so that slow rates get to step.
        cnt = feg_pkg::CNT_W'($urandom_range(16383));
        if ($urandom_range(1)) begin
          cnt = cnt & ~((feg_pkg::CNT_W'(1) << $urandom_range(11)) - feg_pkg::CNT_W'(1));
        end
        send_item(cmd, cnt, 1'b0, '0);
      end
    end

    wait_for_idle();
    if (error_count == 0 && envelope_due.size() == 0) begin
      $display("tb_filter_envelope_generator_core: clean");
    end else begin
      $display("tb_filter_envelope_generator_core: errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("tb_filter_envelope_generator_core: errors");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/feg_pkg.sv
rtl/core/feg_cfg.sv
rtl/core/feg_rate.sv
rtl/core/feg_next.sv
rtl/core/filter_envelope_generator_core.sv
rtl/core/feg_checker.sv
dv/tb_filter_envelope_generator_core.sv
